@@ rtl/core/lpdf_pkg.sv @@
// shared types, constants and the prefix table of the line prefix drop filter
// no dependencies
package lpdf_pkg;

  localparam int PREFIX_LEN_DEFAULT = 17;
  localparam int PREFIX_IDX_W       = 6;
  localparam int BYTE_W             = 8;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

  typedef struct packed {
    logic accept;
    logic read;
    logic load;
  } lpdf_cmd_t;

  typedef struct packed {
    logic replay_req;
    logic rd_last;
    logic out_busy;
  } lpdf_status_t;

  // ":0300000040DF07D7", zero past its end
  function automatic logic [BYTE_W-1:0] prefix_byte(input logic [PREFIX_IDX_W-1:0] idx);
    logic [BYTE_W-1:0] ch;
    unique case (idx)
      6'd0:    ch = 8'h3A;
      6'd1:    ch = 8'h30;
      6'd2:    ch = 8'h33;
      6'd3:    ch = 8'h30;
      6'd4:    ch = 8'h30;
      6'd5:    ch = 8'h30;
      6'd6:    ch = 8'h30;
      6'd7:    ch = 8'h30;
      6'd8:    ch = 8'h30;
      6'd9:    ch = 8'h34;
      6'd10:   ch = 8'h30;
      6'd11:   ch = 8'h44;
      6'd12:   ch = 8'h46;
      6'd13:   ch = 8'h30;
      6'd14:   ch = 8'h37;
      6'd15:   ch = 8'h44;
      6'd16:   ch = 8'h37;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/core/line_prefix_drop_filter.sv @@
// a passed byte is registered in the output register, appearing in the cycle after its
// transfer; a held run of n bytes is replayed through the read and load states in turn:
// the registered line buffer ram read feeds the output register, loads waiting on a stall
// throughput: one input per cycle while no run is replayed and the output is not stalled
// reset: synchronous, clears state, held count, drop flag and output valid; buffer undefined
// top level: joins lpdf_ctrl and lpdf_datapath, depends on lpdf_pkg
module line_prefix_drop_filter #(
  parameter int PREFIX_LEN = lpdf_pkg::PREFIX_LEN_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [lpdf_pkg::BYTE_W-1:0] s_tdata,   // in_byte
  input  logic                        s_tuser,   // end_of_stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [lpdf_pkg::BYTE_W-1:0] m_tdata,   // out_byte
  output logic                        m_tlast    // last_of_run
);

  lpdf_pkg::lpdf_cmd_t    cmd;
  lpdf_pkg::lpdf_status_t status;

  lpdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  lpdf_datapath #(
    .PREFIX_LEN (PREFIX_LEN)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

@@ rtl/core/lpdf_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module lpdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 17
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/lpdf_ctrl.sv @@
// controller of the line prefix drop filter: accept, replay read and load sequencing
// depends on lpdf_pkg
module lpdf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output lpdf_pkg::lpdf_cmd_t   cmd,
  input  lpdf_pkg::lpdf_status_t status
);

  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_READ,
    ST_LOAD
  } state_t;

  state_t state;

  assign s_tready   = (state == ST_ACCEPT) && !status.out_busy;
  assign cmd.accept = s_tvalid && s_tready;
  assign cmd.read   = (state == ST_READ);
  assign cmd.load   = (state == ST_LOAD) && !status.out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCEPT;
    end else begin
      unique case (state)
        ST_ACCEPT: begin
          if (cmd.accept && status.replay_req) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (cmd.load) begin
            state <= status.rd_last ? ST_ACCEPT : ST_READ;
          end
        end
        default: state <= ST_ACCEPT;
      endcase
    end
  end

endmodule

@@ rtl/core/lpdf_datapath.sv @@
// datapath of the line prefix drop filter: line buffer, counters, match, output register
// depends on lpdf_pkg and lpdf_ram
module lpdf_datapath #(
  parameter int PREFIX_LEN = lpdf_pkg::PREFIX_LEN_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [lpdf_pkg::BYTE_W-1:0]     s_tdata,
  input  logic                            s_tuser,
  input  logic                            m_tready,
  output logic                            m_tvalid,
  output logic [lpdf_pkg::BYTE_W-1:0]     m_tdata,
  output logic                            m_tlast,
  input  lpdf_pkg::lpdf_cmd_t             cmd,
  output lpdf_pkg::lpdf_status_t          status
);

  localparam int CW = $clog2(PREFIX_LEN + 1);
  localparam int AW = (PREFIX_LEN > 1) ? $clog2(PREFIX_LEN) : 1;
  localparam logic [CW-1:0] FULL = CW'(PREFIX_LEN);

  logic [CW-1:0] count, count_next, cnt_inc, replay_len, replay_len_next;
  logic          drop, drop_next;
  logic          match, match_next, m_now;
  logic [AW-1:0] rd_idx;
  logic          wr_en, replay_req, pass_req, is_nl;
  logic [lpdf_pkg::BYTE_W-1:0] rd_data;

  assign is_nl   = (s_tdata == lpdf_pkg::NEWLINE_BYTE);
  assign cnt_inc = count + CW'(1);
  assign m_now   = ((count == '0) || match) &&
                   (s_tdata == lpdf_pkg::prefix_byte(lpdf_pkg::PREFIX_IDX_W'(count)));

  always_comb begin
    count_next      = count;
    drop_next       = drop;
    match_next      = match;
    replay_len_next = replay_len;
    wr_en           = 1'b0;
    replay_req      = 1'b0;
    pass_req        = 1'b0;
    priority if (s_tuser) begin
      replay_req      = !drop && (count < FULL) && (count != '0);
      replay_len_next = count;
      drop_next       = 1'b0;
      count_next      = '0;
    end else if (drop) begin
      if (is_nl) begin
        drop_next  = 1'b0;
        count_next = '0;
      end
    end else if (count < FULL) begin
      wr_en      = cmd.accept;
      match_next = m_now;
      if ((cnt_inc == FULL) && !is_nl && m_now) begin
        drop_next  = 1'b1;
        count_next = cnt_inc;
      end else if (is_nl) begin
        replay_req      = 1'b1;
        replay_len_next = cnt_inc;
        count_next      = '0;
      end else begin
        count_next = cnt_inc;
        if (cnt_inc == FULL) begin
          replay_req      = 1'b1;
          replay_len_next = cnt_inc;
        end
      end
    end else begin
      pass_req = 1'b1;
      if (is_nl) begin
        count_next = '0;
      end
    end
  end

  assign status.replay_req = replay_req;
  assign status.rd_last    = ((CW'(rd_idx) + CW'(1)) == replay_len);
  assign status.out_busy   = m_tvalid && !m_tready;

  lpdf_ram #(
    .WIDTH (lpdf_pkg::BYTE_W),
    .DEPTH (PREFIX_LEN)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (s_tdata),
    .rd_en   (cmd.read),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      drop     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        count <= count_next;
        drop  <= drop_next;
      end
      if ((cmd.accept && pass_req) || cmd.load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      match      <= match_next;
      replay_len <= replay_len_next;
      rd_idx     <= '0;
      if (pass_req) begin
        m_tdata <= s_tdata;
        m_tlast <= 1'b1;
      end
    end
    if (cmd.load) begin
      m_tdata <= rd_data;
      m_tlast <= status.rd_last;
      rd_idx  <= rd_idx + AW'(1);
    end
  end

endmodule
